>>> src/life_grid_generation_engine_core_macros.svh
// ---------------------------------------------------------------------------
// Life grid engine assertion macros
// Shared macros for the concurrent checks of the life grid engine.
// ---------------------------------------------------------------------------
`ifndef LIFE_GRID_GENERATION_ENGINE_CORE_MACROS_SVH
`define LIFE_GRID_GENERATION_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LGGE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("life grid engine check failed");

// Next-cycle implication, checked outside reset.
`define LGGE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("life grid engine check failed");

`endif

>>> src/lgge_pkg.sv
// ---------------------------------------------------------------------------
// Life grid engine package
// Grid dimensions, field widths, command codes and shared control types.
// ---------------------------------------------------------------------------
package lgge_pkg;

    localparam int GRID_ROWS = 8;
    localparam int GRID_COLS = 16;
    localparam int ROW_W     = $clog2(GRID_ROWS);

    localparam int IDX_W     = 3;
    localparam int CELLS_W   = 16;
    localparam int CMD_W     = 2;
    localparam int TDATA_W   = ((IDX_W + CELLS_W + 7) / 8) * 8;
    localparam int PAD_W     = TDATA_W - IDX_W - CELLS_W;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_ROWS - 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_READ  = 2'd2
    } lgge_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } lgge_state_t;

    typedef struct packed {
        logic             write_en;
        logic             calc_en;
        logic             calc_last;
        logic             emit_load;
        logic [ROW_W-1:0] row_sel;
    } lgge_ctl_t;

endpackage

>>> src/lgge_ctrl.sv
// ---------------------------------------------------------------------------
// Life grid engine controller
// Command decoding, row sequencing and output word handshake.
// ---------------------------------------------------------------------------
module lgge_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [lgge_pkg::CMD_W-1:0]     in_cmd,
    output logic                           in_ready,
    output logic                           out_valid,
    input  logic                           out_ready,
    output lgge_pkg::lgge_ctl_t            ctl
);

    lgge_pkg::lgge_state_t           state_reg;
    lgge_pkg::lgge_state_t           state_next;
    logic [lgge_pkg::ROW_W-1:0]      cnt_reg;
    logic [lgge_pkg::ROW_W-1:0]      cnt_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            in_fire;
    logic                            slot_free;

    assign in_ready  = (state_reg == lgge_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lgge_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lgge_pkg::ST_IDLE:
            begin
                if (in_fire && (in_cmd == lgge_pkg::CMD_STEP))
                    state_next = lgge_pkg::ST_CALC;
                else if (in_fire && (in_cmd == lgge_pkg::CMD_READ))
                    state_next = lgge_pkg::ST_EMIT;
            end
            lgge_pkg::ST_CALC:
            begin
                if (cnt_reg == lgge_pkg::LAST_ROW)
                    state_next = lgge_pkg::ST_EMIT;
            end
            lgge_pkg::ST_EMIT:
            begin
                if (slot_free && (cnt_reg == lgge_pkg::LAST_ROW))
                    state_next = lgge_pkg::ST_IDLE;
            end
            default:
                state_next = lgge_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl            = '0;
        ctl.row_sel    = cnt_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            lgge_pkg::ST_IDLE:
            begin
                cnt_next     = '0;
                ctl.write_en = in_fire && (in_cmd == lgge_pkg::CMD_WRITE);
            end
            lgge_pkg::ST_CALC:
            begin
                ctl.calc_en   = 1'b1;
                ctl.calc_last = (cnt_reg == lgge_pkg::LAST_ROW);
                cnt_next      = (cnt_reg == lgge_pkg::LAST_ROW) ? '0
                              : cnt_reg + lgge_pkg::ROW_W'(1);
            end
            lgge_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    ctl.emit_load  = 1'b1;
                    out_valid_next = 1'b1;
                    cnt_next       = (cnt_reg == lgge_pkg::LAST_ROW) ? '0
                                   : cnt_reg + lgge_pkg::ROW_W'(1);
                end
            end
            default:
                cnt_next = '0;
        endcase
    end

endmodule

>>> src/lgge_datapath.sv
// ---------------------------------------------------------------------------
// Life grid engine datapath
// Grid storage, one-row-per-cycle generation update and output word register.
// ---------------------------------------------------------------------------
module lgge_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lgge_pkg::lgge_ctl_t             ctl,
    input  logic [lgge_pkg::IDX_W-1:0]      row_index,
    input  logic [lgge_pkg::CELLS_W-1:0]    row_bits,
    output logic [lgge_pkg::IDX_W-1:0]      out_row,
    output logic [lgge_pkg::CELLS_W-1:0]    out_cells,
    output logic                            last_row
);

    logic [lgge_pkg::GRID_COLS-1:0] grid_reg  [lgge_pkg::GRID_ROWS];
    logic [lgge_pkg::GRID_COLS-1:0] grid_next [lgge_pkg::GRID_ROWS];
    logic [lgge_pkg::GRID_COLS-1:0] new_reg   [lgge_pkg::GRID_ROWS];
    logic [lgge_pkg::GRID_COLS-1:0] new_next  [lgge_pkg::GRID_ROWS];
    logic [lgge_pkg::GRID_COLS-1:0] up_row;
    logic [lgge_pkg::GRID_COLS-1:0] cur_row;
    logic [lgge_pkg::GRID_COLS-1:0] dn_row;
    logic [lgge_pkg::GRID_COLS-1:0] calc_row;
    logic [lgge_pkg::IDX_W-1:0]     out_row_reg;
    logic [lgge_pkg::CELLS_W-1:0]   out_cells_reg;
    logic                           last_row_reg;

    assign up_row  = grid_reg[lgge_pkg::GRID_ROWS-1];
    assign cur_row = grid_reg[0];
    assign dn_row  = grid_reg[1];

    // The grid rotates up by one row per update cycle, so the row being
    // computed always sits at index zero with its neighbors at fixed taps.
    always_comb
    begin
        logic [lgge_pkg::GRID_COLS-1:0] up_l;
        logic [lgge_pkg::GRID_COLS-1:0] up_r;
        logic [lgge_pkg::GRID_COLS-1:0] cur_l;
        logic [lgge_pkg::GRID_COLS-1:0] cur_r;
        logic [lgge_pkg::GRID_COLS-1:0] dn_l;
        logic [lgge_pkg::GRID_COLS-1:0] dn_r;
        logic [3:0]                     n;
        up_l  = {up_row[lgge_pkg::GRID_COLS-2:0], up_row[lgge_pkg::GRID_COLS-1]};
        up_r  = {up_row[0], up_row[lgge_pkg::GRID_COLS-1:1]};
        cur_l = {cur_row[lgge_pkg::GRID_COLS-2:0], cur_row[lgge_pkg::GRID_COLS-1]};
        cur_r = {cur_row[0], cur_row[lgge_pkg::GRID_COLS-1:1]};
        dn_l  = {dn_row[lgge_pkg::GRID_COLS-2:0], dn_row[lgge_pkg::GRID_COLS-1]};
        dn_r  = {dn_row[0], dn_row[lgge_pkg::GRID_COLS-1:1]};
        n     = '0;
        for (int c = 0; c < lgge_pkg::GRID_COLS; c++)
        begin
            n = 4'(up_l[c]) + 4'(up_row[c]) + 4'(up_r[c]) + 4'(cur_l[c])
              + 4'(cur_r[c]) + 4'(dn_l[c]) + 4'(dn_row[c]) + 4'(dn_r[c]);
            calc_row[c] = (n == 4'd3) || (cur_row[c] && (n == 4'd2));
        end
    end

    always_comb
    begin
        grid_next = grid_reg;
        new_next  = new_reg;
        if (ctl.write_en)
        begin
            if ({1'b0, row_index} < (lgge_pkg::IDX_W + 1)'(lgge_pkg::GRID_ROWS))
                grid_next[row_index] = row_bits[lgge_pkg::GRID_COLS-1:0];
        end
        else if (ctl.calc_en)
        begin
            for (int i = 0; i < lgge_pkg::GRID_ROWS - 1; i++)
            begin
                new_next[i] = new_reg[i+1];
            end
            new_next[lgge_pkg::GRID_ROWS-1] = calc_row;
            if (ctl.calc_last)
            begin
                for (int i = 0; i < lgge_pkg::GRID_ROWS - 1; i++)
                begin
                    grid_next[i] = new_reg[i+1];
                end
                grid_next[lgge_pkg::GRID_ROWS-1] = calc_row;
            end
            else
            begin
                for (int i = 0; i < lgge_pkg::GRID_ROWS - 1; i++)
                begin
                    grid_next[i] = grid_reg[i+1];
                end
                grid_next[lgge_pkg::GRID_ROWS-1] = grid_reg[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lgge_pkg::GRID_ROWS; i++)
            begin
                grid_reg[i] <= '0;
            end
        end
        else
        begin
            grid_reg <= grid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_reg <= new_next;
        if (ctl.emit_load)
        begin
            out_row_reg   <= lgge_pkg::IDX_W'(ctl.row_sel);
            out_cells_reg <= lgge_pkg::CELLS_W'(grid_reg[ctl.row_sel]);
            last_row_reg  <= (ctl.row_sel == lgge_pkg::LAST_ROW);
        end
    end

    assign out_row   = out_row_reg;
    assign out_cells = out_cells_reg;
    assign last_row  = last_row_reg;

endmodule

>>> src/life_grid_generation_engine_core.sv
// ---------------------------------------------------------------------------
// Life grid generation engine core
// Toroidal B3/S23 cellular automaton on an 8 by 16 grid with a stream port.
// ---------------------------------------------------------------------------
// A write word stores one row. A read word emits the grid as eight output
// words, one row per cycle while the output side is ready. A step word first
// runs the single row update unit over the grid, one row per cycle, commits
// the new generation and then emits it. The grid rotates through the update
// unit, so the input stays busy during an update and the following output
// burst. The grid is all dead after reset.
`include "life_grid_generation_engine_core_macros.svh"

module life_grid_generation_engine_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // row_index [2:0], row_bits [18:3], zero fill above.
    input  logic [lgge_pkg::TDATA_W-1:0]    s_axis_tdata,
    // cmd [1:0].
    input  logic [lgge_pkg::CMD_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_row [2:0], out_cells [18:3], zero fill above.
    output logic [lgge_pkg::TDATA_W-1:0]    m_axis_tdata,
    // last_row.
    output logic                            m_axis_tlast
);

    lgge_pkg::lgge_ctl_t              ctl;
    logic [lgge_pkg::IDX_W-1:0]       out_row;
    logic [lgge_pkg::CELLS_W-1:0]     out_cells;

    lgge_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_cmd    (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .ctl       (ctl)
    );

    lgge_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .row_index (s_axis_tdata[lgge_pkg::IDX_W-1:0]),
        .row_bits  (s_axis_tdata[lgge_pkg::IDX_W+lgge_pkg::CELLS_W-1:lgge_pkg::IDX_W]),
        .out_row   (out_row),
        .out_cells (out_cells),
        .last_row  (m_axis_tlast)
    );

    assign m_axis_tdata = {{lgge_pkg::PAD_W{1'b0}}, out_cells, out_row};

    `LGGE_ASSERT_SAME(a_last_is_final_row, clk, rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tdata[lgge_pkg::IDX_W-1:0] == lgge_pkg::IDX_W'(lgge_pkg::GRID_ROWS - 1))
    `LGGE_ASSERT_SAME(a_busy_during_update, clk, rst_n, ctl.calc_en, !s_axis_tready && !ctl.emit_load)
    `LGGE_ASSERT_NEXT(a_step_starts_update, clk, rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser == lgge_pkg::CMD_STEP), ctl.calc_en && (ctl.row_sel == '0))

endmodule

>>> tb/sv/life_grid_generation_engine_core_tb.sv
// ---------------------------------------------------------------------------
// Life grid generation engine testbench
// Streams write, step, read and unused command words into the engine and
// compares every emitted row word with a row-by-row prediction of the
// toroidal B3/S23 grid, with random idle cycles on both stream sides.
// ---------------------------------------------------------------------------

typedef struct packed {
    logic [lgge_pkg::IDX_W-1:0]   row;
    logic [lgge_pkg::CELLS_W-1:0] cells;
    logic                         last;
} grid_row_t;

class grid_row_scoreboard;

    logic [lgge_pkg::GRID_COLS-1:0] grid [lgge_pkg::GRID_ROWS];
    grid_row_t expected_rows [$];
    int writes;
    int steps;
    int reads;
    int unused;
    int rows_checked;
    int errors;

    function new();
        foreach (grid[r])
        begin
            grid[r] = '0;
        end
    endfunction

    function void queue_grid();
        grid_row_t item;
        for (int r = 0; r < lgge_pkg::GRID_ROWS; r++)
        begin
            item.row   = (lgge_pkg::IDX_W)'(r);
            item.cells = grid[r];
            item.last  = (r == lgge_pkg::GRID_ROWS - 1);
            expected_rows.push_back(item);
        end
    endfunction

    function void note_word(logic [lgge_pkg::CMD_W-1:0] cmd,
                            logic [lgge_pkg::IDX_W-1:0] idx,
                            logic [lgge_pkg::CELLS_W-1:0] bits);
        logic [lgge_pkg::GRID_COLS-1:0] next_grid [lgge_pkg::GRID_ROWS];
        int up;
        int dn;
        int lf;
        int rt;
        int live;
        case (cmd)
            lgge_pkg::CMD_WRITE:
            begin
                writes++;
                if (idx < lgge_pkg::GRID_ROWS)
                begin
                    grid[idx] = bits[lgge_pkg::GRID_COLS-1:0];
                end
            end
            lgge_pkg::CMD_STEP:
            begin
                steps++;
                for (int r = 0; r < lgge_pkg::GRID_ROWS; r++)
                begin
                    up = (r + lgge_pkg::GRID_ROWS - 1) % lgge_pkg::GRID_ROWS;
                    dn = (r + 1) % lgge_pkg::GRID_ROWS;
                    for (int c = 0; c < lgge_pkg::GRID_COLS; c++)
                    begin
                        lf = (c + lgge_pkg::GRID_COLS - 1) % lgge_pkg::GRID_COLS;
                        rt = (c + 1) % lgge_pkg::GRID_COLS;
                        live = grid[up][lf] + grid[up][c] + grid[up][rt]
                             + grid[r][lf] + grid[r][rt]
                             + grid[dn][lf] + grid[dn][c] + grid[dn][rt];
                        next_grid[r][c] = (live == 3) || (grid[r][c] && live == 2);
                    end
                end
                grid = next_grid;
                queue_grid();
            end
            lgge_pkg::CMD_READ:
            begin
                reads++;
                queue_grid();
            end
            default:
            begin
                unused++;
            end
        endcase
    endfunction

    function void check_row(logic [lgge_pkg::IDX_W-1:0] row,
                            logic [lgge_pkg::CELLS_W-1:0] cells,
                            logic last);
        grid_row_t want;
        rows_checked++;
        if (expected_rows.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected row word, expected none, got row %0d cells %h last %b",
                     $time, row, cells, last);
            return;
        end
        want = expected_rows.pop_front();
        if (row !== want.row || cells !== want.cells || last !== want.last)
        begin
            errors++;
            $display("%0t: row word mismatch, expected row %0d cells %h last %b,",
                     $time, want.row, want.cells, want.last);
            $display("    got row %0d cells %h last %b", row, cells, last);
        end
    endfunction

endclass

module life_grid_generation_engine_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [lgge_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int WORD_TARGET = 420;
    localparam int CYCLE_LIMIT = 300000;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [lgge_pkg::TDATA_W-1:0]   s_axis_tdata = '0;
    logic [lgge_pkg::CMD_W-1:0]     s_axis_tuser = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [lgge_pkg::TDATA_W-1:0]   m_axis_tdata;
    logic                           m_axis_tlast;

    logic               steady = 1'b0;
    int                 words_sent = 0;
    int                 cycle_count = 0;
    grid_row_scoreboard sb;

    life_grid_generation_engine_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                sb.check_row(m_axis_tdata[lgge_pkg::IDX_W-1:0],
                             m_axis_tdata[lgge_pkg::IDX_W +: lgge_pkg::CELLS_W],
                             m_axis_tlast);
            end
            m_axis_tready <= steady || ($urandom_range(99) >= 38);
        end
    end

    task automatic send_word(input logic [lgge_pkg::CMD_W-1:0] cmd,
                             input logic [lgge_pkg::IDX_W-1:0] idx,
                             input logic [lgge_pkg::CELLS_W-1:0] bits);
        while (!steady && $urandom_range(99) < 38)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{lgge_pkg::PAD_W{1'b0}}, bits, idx};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        sb.note_word(cmd, idx, bits);
        if (cmd != CMD_UNUSED)
        begin
            words_sent++;
        end
    endtask

    task automatic wait_for_grid_output();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_rows.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [lgge_pkg::CELLS_W-1:0] random_row(int density);
        logic [lgge_pkg::CELLS_W-1:0] a;
        logic [lgge_pkg::CELLS_W-1:0] b;
        logic [lgge_pkg::CELLS_W-1:0] c;
        a = lgge_pkg::CELLS_W'($urandom);
        b = lgge_pkg::CELLS_W'($urandom);
        c = lgge_pkg::CELLS_W'($urandom);
        case (density)
            0:       return a;
            1:       return a & b;
            2:       return a & b & c;
            default: return a | b;
        endcase
    endfunction

    initial
    begin
        int density;
        int pick;
        int rounds;
        sb = new();
        rounds = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty grid, full rows on the wrapping edge, the unused
        // command, a blinker crossing the corner and a still block.
        send_word(lgge_pkg::CMD_READ, 3'd0, 16'h0000);
        send_word(lgge_pkg::CMD_STEP, 3'd7, 16'hFFFF);
        send_word(lgge_pkg::CMD_WRITE, 3'd0, 16'hFFFF);
        send_word(lgge_pkg::CMD_WRITE, 3'd7, 16'hFFFF);
        send_word(lgge_pkg::CMD_READ, 3'd7, 16'hFFFF);
        send_word(lgge_pkg::CMD_STEP, 3'd0, 16'h0000);
        send_word(CMD_UNUSED, 3'd7, 16'hFFFF);
        send_word(lgge_pkg::CMD_READ, 3'd0, 16'h0000);
        send_word(lgge_pkg::CMD_WRITE, 3'd0, 16'h8003);
        send_word(lgge_pkg::CMD_STEP, 3'd0, 16'h0000);
        send_word(lgge_pkg::CMD_STEP, 3'd0, 16'h0000);
        send_word(lgge_pkg::CMD_WRITE, 3'd0, 16'h0000);
        send_word(lgge_pkg::CMD_WRITE, 3'd3, 16'h0180);
        send_word(lgge_pkg::CMD_WRITE, 3'd4, 16'h0180);
        send_word(lgge_pkg::CMD_STEP, 3'd5, 16'h5555);
        send_word(lgge_pkg::CMD_READ, 3'd2, 16'hAAAA);
        wait_for_grid_output();

        // Random part: mostly whole random grids followed by a few generations.
        while (words_sent < WORD_TARGET)
        begin
            if ($urandom_range(99) < 85)
            begin
                density = $urandom_range(3);
                for (int r = 0; r < lgge_pkg::GRID_ROWS; r++)
                begin
                    send_word(lgge_pkg::CMD_WRITE, lgge_pkg::IDX_W'(r), random_row(density));
                end
                repeat ($urandom_range(1, 6))
                begin
                    pick = $urandom_range(99);
                    if (pick < 65)
                    begin
                        send_word(lgge_pkg::CMD_STEP, lgge_pkg::IDX_W'($urandom),
                                  lgge_pkg::CELLS_W'($urandom));
                    end
                    else if (pick < 85)
                    begin
                        send_word(lgge_pkg::CMD_READ, lgge_pkg::IDX_W'($urandom),
                                  lgge_pkg::CELLS_W'($urandom));
                    end
                    else
                    begin
                        send_word(lgge_pkg::CMD_WRITE, lgge_pkg::IDX_W'($urandom),
                                  random_row(density));
                    end
                end
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    send_word(lgge_pkg::CMD_W'($urandom), lgge_pkg::IDX_W'($urandom),
                              lgge_pkg::CELLS_W'($urandom));
                end
            end
            rounds++;
            if (rounds % 10 == 0)
            begin
                wait_for_grid_output();
            end
            steady <= (words_sent >= 180 && words_sent < 260);
        end

        wait_for_grid_output();
        repeat (40) @(posedge clk);

        $display("Covered %0d row writes, %0d generation steps, %0d grid reads, %0d unused words.",
                 sb.writes, sb.steps, sb.reads, sb.unused);
        $display("Compared %0d emitted row words with the predicted grid.", sb.rows_checked);
        if (sb.errors == 0 && sb.expected_rows.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
